// ===== rtl/rss_pkg.sv =====
// shared types and constants for the running sample statistics block
package rss_pkg;

    localparam int unsigned MaxSamples = 65535;
    localparam logic [15:0] SatLimit   = 16'd32767;

    localparam logic FuncAdd   = 1'b0;
    localparam logic FuncClear = 1'b1;

    typedef struct packed {
        logic               func;
        logic signed [15:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        sample_count;
        logic signed [15:0] minimum;
        logic signed [15:0] maximum;
        logic signed [15:0] mean;
        logic signed [15:0] pop_variance;
        logic signed [15:0] pop_deviation;
        logic signed [15:0] sample_deviation;
        logic               rejected;
    } t_out_item;

    // snapshot of the accumulators handed from front to back
    typedef struct packed {
        logic [15:0]        count;
        logic signed [15:0] min_v;
        logic signed [15:0] max_v;
        logic signed [31:0] sum;
        logic [45:0]        sumsq;
        logic               rejected;
    } t_snap;

endpackage

// ===== rtl/rss_front.sv =====
// front part: accumulates count, min, max, sum and sum of squares, or clears them
module rss_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rss_pkg::t_in_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output rss_pkg::t_snap  o_snap,
    input  logic            i_ready
);
    import rss_pkg::*;

    logic [15:0]        r_count, n_count;
    logic signed [15:0] r_min, n_min, r_max, n_max;
    logic signed [31:0] r_sum, n_sum;
    logic [45:0]        r_sumsq, n_sumsq;
    logic               r_valid, r_rej, n_rej;
    logic [31:0]        r_sq;
    logic               r_sq_ok;
    logic signed [15:0] r_s;
    logic               r_func;
    logic signed [31:0] sq_full;

    // square is registered first, then accumulated
    assign o_ready = !r_sq_ok && (!r_valid || i_ready);
    assign sq_full = i_item.sample * i_item.sample;

    always_comb begin
        n_count = r_count;
        n_min   = r_min;
        n_max   = r_max;
        n_sum   = r_sum;
        n_sumsq = r_sumsq;
        n_rej   = 1'b0;
        if (r_func == FuncClear) begin
            n_count = '0;
            n_min   = '0;
            n_max   = '0;
            n_sum   = '0;
            n_sumsq = '0;
        end else if (32'(r_count) >= MaxSamples) begin
            n_rej = 1'b1;
        end else begin
            if (r_count == '0 || r_s < r_min) n_min = r_s;
            if (r_count == '0 || r_s > r_max) n_max = r_s;
            n_sum   = r_sum + 32'(r_s);
            n_sumsq = r_sumsq + 46'(r_sq);
            n_count = r_count + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_valid <= 1'b0;
            r_sq_ok <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_s     <= i_item.sample;
                r_func  <= i_item.func;
                r_sq_ok <= 1'b1;
            end
            if (r_sq_ok) begin
                r_sq_ok <= 1'b0;
                r_count <= n_count;
                r_min   <= n_min;
                r_max   <= n_max;
                r_sum   <= n_sum;
                r_sumsq <= n_sumsq;
                r_rej   <= n_rej;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_sq <= unsigned'(sq_full);
    end

    assign o_valid = r_valid;
    assign o_snap  = '{count: r_count, min_v: r_min, max_v: r_max, sum: r_sum,
                       sumsq: r_sumsq, rejected: r_rej};
endmodule

// ===== rtl/rss_back.sv =====
// back part: sequencer with shared multiplier, divider and square root
module rss_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rss_pkg::t_snap    i_snap,
    output logic              o_ready,
    input  logic signed [15:0] i_marker,
    output logic              o_valid,
    output rss_pkg::t_out_item o_item,
    input  logic              i_ready
);
    import rss_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL   = 10'b0000000010,
        S_DIVM  = 10'b0000000100,
        S_DIVV  = 10'b0000001000,
        S_SQV   = 10'b0000010000,
        S_DIVS  = 10'b0000100000,
        S_SQS   = 10'b0001000000,
        S_OUT   = 10'b0010000000,
        S_MULP  = 10'b0100000000,
        S_PREP  = 10'b1000000000
    } t_state;

    t_state      r_state, n_state;
    t_snap       r_snap;
    logic [6:0]  r_step, n_step;
    logic [2:0]  r_mstep;
    // dividend/remainder for restoring division
    logic [63:0] r_num;
    logic [64:0] r_rem;
    logic [31:0] r_den;
    logic [63:0] r_acc;    // product accumulator
    logic [63:0] r_d;
    logic [15:0] r_mean;
    logic [63:0] r_var;
    logic [15:0] r_pdev;
    // square root state
    logic [63:0] r_sx;
    logic [33:0] r_sr;
    logic [31:0] r_root;
    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    logic [33:0] sq_trial, sq_rem_sh;
    logic [31:0] sabs;
    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [47:0] mul_p;
    t_out_item   r_out;
    logic        r_ov;

    assign sabs  = r_snap.sum[31] ? 32'(-r_snap.sum) : 32'(r_snap.sum);
    assign mul_p = mul_a * mul_b;
    // four 16-bit partial product steps: n*sumsq (46x16 as 2) and sabs^2 (32x32 as 2)
    always_comb begin
        unique case (r_mstep)
            3'd0: begin mul_a = r_snap.sumsq[31:0];        mul_b = r_snap.count;  end
            3'd1: begin mul_a = 32'(r_snap.sumsq[45:32]);  mul_b = r_snap.count;  end
            3'd2: begin mul_a = sabs;                      mul_b = sabs[15:0];    end
            3'd3: begin mul_a = sabs;                      mul_b = sabs[31:16];   end
            default: begin mul_a = '0;                     mul_b = '0;            end
        endcase
    end

    assign rem_sh  = {r_rem[63:0], r_num[63]};
    assign rem_sub = rem_sh - {33'd0, r_den};
    assign sq_rem_sh = {r_sr[31:0], r_sx[63:62]};
    assign sq_trial  = sq_rem_sh - {r_root[31:0], 2'b01};

    function automatic logic [15:0] sat16(input logic [63:0] v);
        sat16 = (v > 64'(SatLimit)) ? SatLimit : v[15:0];
    endfunction

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_ov) begin
                        r_snap  <= i_snap;
                        r_mstep <= '0;
                        r_acc   <= '0;
                        r_state <= (i_snap.count == '0) ? S_OUT : S_MUL;
                    end
                end
                S_MUL: begin
                    unique case (r_mstep)
                        3'd0: r_acc <= 64'(mul_p);
                        3'd1: r_acc <= r_acc + {mul_p[31:0], 32'd0};
                        3'd2: r_d   <= r_acc - 64'(mul_p);
                        default: r_d <= r_d - {mul_p[47:0], 16'd0};
                    endcase
                    r_mstep <= r_mstep + 3'd1;
                    if (r_mstep == 3'd3) r_state <= S_MULP;
                end
                S_MULP: begin
                    // mean: divide |sum| by n
                    r_num   <= {sabs, 32'd0};
                    r_rem   <= '0;
                    r_den   <= 32'(r_snap.count);
                    r_step  <= 7'd32;
                    r_state <= S_DIVM;
                end
                S_DIVM, S_DIVV, S_DIVS: begin
                    if (r_step == '0) begin
                        if (r_state == S_DIVM) begin
                            r_mean  <= r_snap.sum[31] ? 16'(-r_num[31:0]) : r_num[15:0];
                            r_num   <= r_d;
                            r_rem   <= '0;
                            r_den   <= 32'(r_snap.count) * 32'(r_snap.count);
                            r_step  <= 7'd64;
                            r_state <= S_DIVV;
                        end else begin
                            if (r_state == S_DIVV) r_var <= r_num;
                            r_sx    <= r_num;
                            r_sr    <= '0;
                            r_root  <= '0;
                            r_step  <= 7'd32;
                            r_state <= (r_state == S_DIVV) ? S_SQV : S_SQS;
                        end
                    end else begin
                        if (!rem_sub[64]) begin
                            r_rem <= rem_sub;
                            r_num <= {r_num[62:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_num <= {r_num[62:0], 1'b0};
                        end
                        r_step <= r_step - 7'd1;
                    end
                end
                S_SQV, S_SQS: begin
                    if (r_step == '0) begin
                        if (r_state == S_SQV) begin
                            r_pdev <= sat16(64'(r_root));
                            if (r_snap.count < 16'd2) begin
                                r_state <= S_OUT;
                            end else begin
                                r_num   <= r_d;
                                r_rem   <= '0;
                                r_den   <= 32'(r_snap.count) * 32'(r_snap.count - 16'd1);
                                r_step  <= 7'd64;
                                r_state <= S_DIVS;
                            end
                        end else begin
                            r_state <= S_PREP;
                        end
                    end else begin
                        if (!sq_trial[33]) begin
                            r_sr   <= sq_trial;
                            r_root <= {r_root[30:0], 1'b1};
                        end else begin
                            r_sr   <= sq_rem_sh;
                            r_root <= {r_root[30:0], 1'b0};
                        end
                        r_sx   <= {r_sx[61:0], 2'b00};
                        r_step <= r_step - 7'd1;
                    end
                end
                S_PREP, S_OUT: begin
                    if (!r_ov) begin
                        r_out.sample_count <= r_snap.count;
                        r_out.minimum      <= r_snap.min_v;
                        r_out.maximum      <= r_snap.max_v;
                        r_out.rejected     <= r_snap.rejected;
                        if (r_snap.count == '0) begin
                            r_out.mean          <= i_marker;
                            r_out.pop_variance  <= i_marker;
                            r_out.pop_deviation <= i_marker;
                        end else begin
                            r_out.mean          <= r_mean;
                            r_out.pop_variance  <= sat16(r_var);
                            r_out.pop_deviation <= r_pdev;
                        end
                        r_out.sample_deviation <= (r_state == S_PREP)
                                                  ? sat16(64'(r_root)) : i_marker;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/running_sample_statistics_core.sv =====
// top level of the running sample statistics block
// One result per item. The front registers the sample square and then
// updates the accumulators; a one-entry hand-off holds the snapshot.
// The back works each item through one shared 32x16 multiplier,
// a radix-2 divider (32 steps for the mean, 64 each for both variances) and
// a bit-pair square root (32 steps each); an item after clear skips the
// arithmetic. The front can take the next item into the hand-off while the
// back is busy; the back works items one at a time. The empty_marker
// register should be written only while the block is idle.
module running_sample_statistics_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  rss_pkg::t_in_item   i_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output rss_pkg::t_out_item  o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic signed [15:0]  i_cfg_data
);
    import rss_pkg::*;

    logic               r_marker;
    logic signed [15:0] r_empty_marker;
    logic               f_ready, q_valid, b_ready, b_valid;
    t_snap              q_snap;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_marker <= 16'sh8000;
            r_marker       <= 1'b0;
        end else if (i_cfg_valid) begin
            r_empty_marker <= i_cfg_data;
            r_marker       <= 1'b1;
        end
    end

    rss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push),
        .i_item  (i_item),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .o_snap  (q_snap),
        .i_ready (b_ready)
    );

    rss_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_snap   (q_snap),
        .o_ready  (b_ready),
        .i_marker (r_empty_marker),
        .o_valid  (b_valid),
        .o_item   (o_item),
        .i_ready  (pop)
    );

    assign full  = !f_ready;
    assign empty = !b_valid;

    a_marker_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_empty_marker == 16'sh8000 && !r_marker))
        else $error("marker not reset");
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("result changed before pop");
    a_count_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.sample_count == 16'd0) |->
        (o_item.minimum == 16'sd0 && o_item.maximum == 16'sd0))
        else $error("empty result with nonzero min or max");
endmodule
